>>> sv/mfe_pkg.sv
`timescale 1ns / 1ps

package mfe_pkg;

  // Default grid store size
  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;

  // Register reset values and widths
  localparam int       CfgW      = 7;
  localparam int       CfgIdxW   = 2;
  localparam bit [6:0] RowsReset = 7'd16;
  localparam bit [6:0] ColsReset = 7'd16;

  // Register indexes
  localparam bit [1:0] RegRows = 2'd0;
  localparam bit [1:0] RegCols = 2'd1;

  // Action codes
  localparam bit [1:0] ActClear = 2'd0;
  localparam bit [1:0] ActOpen  = 2'd1;
  localparam bit [1:0] ActStep  = 2'd2;
  localparam bit [1:0] ActRead  = 2'd3;

  // Status codes
  localparam bit [1:0] StOk      = 2'd0;
  localparam bit [1:0] StNoCand  = 2'd1;
  localparam bit [1:0] StOutRng  = 2'd2;

  // Candidate count saturation on the result
  localparam int CountW   = 15;
  localparam int CountSat = 32767;

  // Stream widths
  localparam int InDataW  = 48;
  localparam int OutDataW = 32;
  localparam int RandW    = 32;

endpackage

>>> sv/mfe_grid_mem.sv
`timescale 1ns / 1ps

// Single-port row store with registered synchronous read
module mfe_grid_mem #(
  parameter int Depth = mfe_pkg::MaxRowsDef,
  parameter int Width = mfe_pkg::MaxColsDef
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mfe_mod.sv
`timescale 1ns / 1ps

// Restoring modulo, one dividend bit per cycle
module mfe_mod #(
  parameter int DivW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [mfe_pkg::RandW-1:0] dividend_i,
  input  logic [DivW-1:0]          divisor_i,
  output logic                     done_o,
  output logic [DivW-1:0]          rem_o
);

  localparam int CntW = $clog2(mfe_pkg::RandW + 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [mfe_pkg::RandW-1:0] dvd_q, dvd_d;
  logic [DivW-1:0]           dvs_q, dvs_d;
  logic [DivW:0]             rem_q, rem_d;
  logic [DivW:0]             shifted;

  assign shifted = {rem_q[DivW-1:0], dvd_q[mfe_pkg::RandW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(mfe_pkg::RandW);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in one bit, subtract when it fits
      dvd_d = {dvd_q[mfe_pkg::RandW-2:0], 1'b0};
      rem_d = (shifted >= {1'b0, dvs_q}) ? shifted - {1'b0, dvs_q} : shifted;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DivW-1:0];

endmodule

>>> sv/maze_frontier_expansion_step.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (lowest bit first)
// s_axis    in   action[1:0] cell_row[7:2] cell_col[13:8] random_value[45:14]
// m_axis    out  status[1:0] cell_bit[2] opened_row[8:3] opened_col[14:9]
//                candidate_count[29:15]
// cfg       in   cfg_we_i, cfg_idx_i (0 rows, 1 cols), cfg_wdata_i
//
// A step makes two row-serial scans of the single-port row store, one cell per
// cycle once its rows are read, with a modulo between them. After reset a
// clearing pass fills the store with ones; no item is taken meanwhile. One item
// is in work at a time; the next is taken while a finished result still waits
// on m_axis.
module maze_frontier_expansion_step #(
  parameter int MAX_ROWS = mfe_pkg::MaxRowsDef,
  parameter int MAX_COLS = mfe_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mfe_pkg::InDataW-1:0]  s_axis_tdata,  // action, cell_row, cell_col, random_value
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mfe_pkg::OutDataW-1:0] m_axis_tdata,  // status, cell_bit, opened_row,
                                                      // opened_col, candidate_count
  input  logic                         cfg_we_i,
  input  logic [mfe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mfe_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int NW  = $clog2(4 * MAX_ROWS * MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RW_RD, S_RW, S_RD_UP, S_RD_CUR, S_RD_DN, S_RD_END,
    S_COL, S_MOD, S_WF_RD, S_WF_WR, S_WM_RD, S_WM_WR, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [6:0]          rows_q, cols_q;
  logic                boot_q, boot_d;
  logic [RAW-1:0]      clr_q, clr_d;
  logic [1:0]          act_q, act_d;
  logic [5:0]          row_q, row_d, col_q, col_d;
  logic [31:0]         rnd_q, rnd_d;
  logic [RAW-1:0]      r_q, r_d, tr_q, tr_d, hr_q, hr_d;
  logic [CAW-1:0]      c_q, c_d, tc_q, tc_d, hc_q, hc_d;
  logic                pass_q, pass_d;
  logic [NW-1:0]       n_q, n_d, tot_q, tot_d, pick_q, pick_d;
  logic [MAX_COLS-1:0] up_q, up_d, cur_q, cur_d, dn_q, dn_d;
  logic [1:0]          st_q, st_d;
  logic                bit_q, bit_d;
  logic                out_valid_q, out_valid_d;
  logic [29:0]         out_q, out_d;

  logic [RW-1:0]       eff_rows;
  logic [CW-1:0]       eff_cols;
  logic [RAW-1:0]      mem_addr;
  logic                mem_we;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;
  logic                mod_start, mod_done;
  logic [NW-1:0]       mod_rem;
  logic                in_fire, out_fire;

  logic [3:0]          flg;
  logic [2:0]          k;
  logic [NW-1:0]       off;
  logic [1:0]          seen;
  logic [1:0]          dsel;
  logic                last_col, last_row, hit, out_rng;
  logic [14:0]         cnt_sat;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Effective grid size: register saturated to the store size
  assign eff_rows = (32'(rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q);
  assign eff_cols = (32'(cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= mfe_pkg::RowsReset;
      cols_q <= mfe_pkg::ColsReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mfe_pkg::RegRows) begin
        rows_q <= cfg_wdata_i;
      end else if (cfg_idx_i == mfe_pkg::RegCols) begin
        cols_q <= cfg_wdata_i;
      end
    end
  end

  // Candidate flags of the current cell: up, down, left, right
  always_comb begin
    flg = '0;
    if (!cur_q[c_q]) begin
      flg[0] = up_q[c_q];
      flg[1] = dn_q[c_q];
      flg[2] = (c_q >= CAW'(2)) && cur_q[CAW'(32'(c_q) - 2)];
      flg[3] = (32'(c_q) + 2 < 32'(eff_cols)) && cur_q[CAW'(32'(c_q) + 2)];
    end
    k = 3'({2'b0, flg[0]} + {2'b0, flg[1]} + {2'b0, flg[2]} + {2'b0, flg[3]});
    off = pick_q - n_q;
    hit = (pick_q >= n_q) && (pick_q < n_q + NW'(k));
    // pick the off-th set flag in order
    seen = '0;
    dsel = '0;
    for (int d = 0; d < 4; d++) begin
      if (flg[d]) begin
        if (NW'(seen) == off) begin
          dsel = 2'(d);
        end
        seen = seen + 2'd1;
      end
    end
    last_col = (32'(c_q) + 1 == 32'(eff_cols));
    last_row = (32'(r_q) + 1 == 32'(eff_rows));
    out_rng  = (32'(s_axis_tdata[7:2]) >= 32'(eff_rows)) ||
               (32'(s_axis_tdata[13:8]) >= 32'(eff_cols));
    cnt_sat  = (32'(tot_q) > mfe_pkg::CountSat) ? 15'(mfe_pkg::CountSat) : 15'(tot_q);
  end

  // Memory port selection
  always_comb begin
    mem_addr  = r_q;
    mem_we    = 1'b0;
    mem_wdata = mem_rdata;
    case (state_q)
      S_INIT: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = '1;
      end
      S_RW_RD, S_RW: begin
        mem_addr = RAW'(row_q);
        if (state_q == S_RW && act_q == mfe_pkg::ActOpen) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(MAX_COLS'(1) << CAW'(col_q));
        end
      end
      S_RD_UP:  mem_addr = RAW'(32'(r_q) - 2);
      S_RD_CUR: mem_addr = r_q;
      S_RD_DN:  mem_addr = RAW'(32'(r_q) + 2);
      S_WF_RD, S_WF_WR: begin
        mem_addr = tr_q;
        if (state_q == S_WF_WR) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(MAX_COLS'(1) << tc_q);
        end
      end
      S_WM_RD, S_WM_WR: begin
        mem_addr = hr_q;
        if (state_q == S_WM_WR) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(MAX_COLS'(1) << hc_q);
        end
      end
      default: mem_addr = r_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    boot_d      = boot_q;
    clr_d       = clr_q;
    act_d       = act_q;
    row_d       = row_q;
    col_d       = col_q;
    rnd_d       = rnd_q;
    r_d         = r_q;
    c_d         = c_q;
    tr_d        = tr_q;
    tc_d        = tc_q;
    hr_d        = hr_q;
    hc_d        = hc_q;
    pass_d      = pass_q;
    n_d         = n_q;
    tot_d       = tot_q;
    pick_d      = pick_q;
    up_d        = up_q;
    cur_d       = cur_q;
    dn_d        = dn_q;
    st_d        = st_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    mod_start   = 1'b0;

    case (state_q)
      S_INIT: begin
        clr_d = clr_q + RAW'(1);
        if (32'(clr_q) + 1 == MAX_ROWS) begin
          clr_d   = '0;
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          act_d = s_axis_tdata[1:0];
          row_d = s_axis_tdata[7:2];
          col_d = s_axis_tdata[13:8];
          rnd_d = s_axis_tdata[45:14];
          st_d  = mfe_pkg::StOk;
          bit_d = 1'b0;
          tr_d  = '0;
          tc_d  = '0;
          tot_d = '0;
          case (s_axis_tdata[1:0])
            mfe_pkg::ActClear: state_d = S_INIT;
            mfe_pkg::ActStep: begin
              if (eff_rows == '0 || eff_cols == '0) begin
                st_d    = mfe_pkg::StNoCand;
                state_d = S_DONE;
              end else begin
                pass_d  = 1'b0;
                n_d     = '0;
                r_d     = '0;
                state_d = S_RD_UP;
              end
            end
            default: begin
              if (out_rng) begin
                st_d    = mfe_pkg::StOutRng;
                state_d = S_DONE;
              end else begin
                state_d = S_RW_RD;
              end
            end
          endcase
        end
      end
      S_RW_RD: state_d = S_RW;
      S_RW: begin
        if (act_q == mfe_pkg::ActRead) begin
          bit_d = mem_rdata[CAW'(col_q)];
        end
        state_d = S_DONE;
      end
      S_RD_UP:  state_d = S_RD_CUR;
      S_RD_CUR: begin
        up_d    = (r_q >= RAW'(2)) ? mem_rdata : '0;
        state_d = S_RD_DN;
      end
      S_RD_DN: begin
        cur_d   = mem_rdata;
        state_d = S_RD_END;
      end
      S_RD_END: begin
        dn_d    = (32'(r_q) + 2 < 32'(eff_rows)) ? mem_rdata : '0;
        c_d     = '0;
        state_d = S_COL;
      end
      S_COL: begin
        n_d = n_q + NW'(k);
        c_d = c_q + CAW'(1);
        if (pass_q && hit) begin
          // chosen candidate: frontier and middle cells
          tr_d = r_q;
          tc_d = c_q;
          hr_d = r_q;
          hc_d = c_q;
          case (dsel)
            2'd0: begin
              tr_d = RAW'(32'(r_q) - 2);
              hr_d = RAW'(32'(r_q) - 1);
            end
            2'd1: begin
              tr_d = RAW'(32'(r_q) + 2);
              hr_d = RAW'(32'(r_q) + 1);
            end
            2'd2: begin
              tc_d = CAW'(32'(c_q) - 2);
              hc_d = CAW'(32'(c_q) - 1);
            end
            default: begin
              tc_d = CAW'(32'(c_q) + 2);
              hc_d = CAW'(32'(c_q) + 1);
            end
          endcase
          state_d = S_WF_RD;
        end else if (last_col) begin
          if (!last_row) begin
            r_d     = r_q + RAW'(1);
            state_d = S_RD_UP;
          end else if (n_d == '0) begin
            st_d    = mfe_pkg::StNoCand;
            state_d = S_DONE;
          end else begin
            tot_d     = n_d;
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pick_d  = mod_rem;
          pass_d  = 1'b1;
          n_d     = '0;
          r_d     = '0;
          state_d = S_RD_UP;
        end
      end
      S_WF_RD: state_d = S_WF_WR;
      S_WF_WR: state_d = S_WM_RD;
      S_WM_RD: state_d = S_WM_WR;
      S_WM_WR: state_d = S_DONE;
      S_DONE: begin
        // result register free or being emptied
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d = {(act_q == mfe_pkg::ActStep && st_q == mfe_pkg::StOk) ? cnt_sat : 15'd0,
                   6'(tc_q), 6'(tr_q), bit_q, st_q};
          if (!(act_q == mfe_pkg::ActStep && st_q == mfe_pkg::StOk)) begin
            out_d[14:3] = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      boot_q      <= 1'b1;
      clr_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      clr_q       <= clr_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    row_q  <= row_d;
    col_q  <= col_d;
    rnd_q  <= rnd_d;
    r_q    <= r_d;
    c_q    <= c_d;
    tr_q   <= tr_d;
    tc_q   <= tc_d;
    hr_q   <= hr_d;
    hc_q   <= hc_d;
    n_q    <= n_d;
    tot_q  <= tot_d;
    pick_q <= pick_d;
    up_q   <= up_d;
    cur_q  <= cur_d;
    dn_q   <= dn_d;
    st_q   <= st_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  mfe_grid_mem #(
    .Depth (MAX_ROWS),
    .Width (MAX_COLS)
  ) u_mem (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  mfe_mod #(
    .DivW (NW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (n_d),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // Memory is never written while waiting for an item
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("grid store written while idle");

  // The chosen candidate always lies below the total found
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COL && pass_q) |-> (pick_q < tot_q))
    else $error("picked candidate beyond total");

  // A result leaves and no new one is loaded: valid drops next cycle
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && state_q != S_DONE) |=> !m_axis_tvalid)
    else $error("result repeated");

  // Modulo finishes only while the sequencer waits for it
  a_mod_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("modulo result unexpected");

endmodule

>>> tb/sv/tb_maze_frontier_expansion_step.sv
`timescale 1ns / 1ps

// Tracks the maze store and register mirror, predicts one result per transfer
class maze_grid_tracker;
  bit          cells[64][64];
  bit [6:0]    rows_reg;
  bit [6:0]    cols_reg;
  logic [31:0] expected_results[$];
  int          errors;

  function new();
    block_all();
    rows_reg = mfe_pkg::RowsReset;
    cols_reg = mfe_pkg::ColsReset;
    errors   = 0;
  endfunction

  function void block_all();
    foreach (cells[r, c]) cells[r][c] = 1'b1;
  endfunction

  function void write_reg(bit [1:0] idx, bit [6:0] val);
    if (idx == mfe_pkg::RegRows) rows_reg = val;
    else if (idx == mfe_pkg::RegCols) cols_reg = val;
  endfunction

  function int unsigned used_rows();
    return (rows_reg > 64) ? 64 : 32'(rows_reg);
  endfunction

  function int unsigned used_cols();
    return (cols_reg > 64) ? 64 : 32'(cols_reg);
  endfunction

  // Walk frontier candidates in scan order; latch the one numbered want
  function int unsigned walk_frontier(int unsigned want, output int fr, output int fc,
                                      output int mr, output int mc);
    int unsigned nrows, ncols, n;
    int tr, tc, hr, hc;
    bit ok;
    nrows = used_rows();
    ncols = used_cols();
    n  = 0;
    fr = 0; fc = 0; mr = 0; mc = 0;
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        if (cells[r][c]) continue;
        for (int d = 0; d < 4; d++) begin
          tr = r; tc = c; hr = r; hc = c;
          case (d)
            0: begin ok = (r >= 2); tr = r - 2; hr = r - 1; end
            1: begin ok = (r + 2 < nrows); tr = r + 2; hr = r + 1; end
            2: begin ok = (c >= 2); tc = c - 2; hc = c - 1; end
            default: begin ok = (c + 2 < ncols); tc = c + 2; hc = c + 1; end
          endcase
          if (!ok) continue;
          if (!cells[tr][tc]) continue;
          if (n == want) begin
            fr = tr; fc = tc; mr = hr; mc = hc;
          end
          n++;
        end
      end
    end
    return n;
  endfunction

  // Accepted input: update the store and queue the expected result
  function void note_input(logic [47:0] d);
    bit [1:0]    act;
    bit [5:0]    row, col;
    bit [31:0]   rnd;
    bit [1:0]    status;
    bit          cbit;
    bit [5:0]    orow, ocol;
    bit [14:0]   cnt;
    int unsigned n;
    int fr, fc, mr, mc;
    act = d[1:0]; row = d[7:2]; col = d[13:8]; rnd = d[45:14];
    status = mfe_pkg::StOk; cbit = 0; orow = 0; ocol = 0; cnt = 0;
    case (act)
      mfe_pkg::ActClear: block_all();
      mfe_pkg::ActOpen, mfe_pkg::ActRead: begin
        if (row >= used_rows() || col >= used_cols()) status = mfe_pkg::StOutRng;
        else if (act == mfe_pkg::ActOpen) cells[row][col] = 1'b0;
        else cbit = cells[row][col];
      end
      default: begin
        n = walk_frontier(32'hFFFF_FFFF, fr, fc, mr, mc);
        if (n == 0) begin
          status = mfe_pkg::StNoCand;
        end else begin
          void'(walk_frontier(rnd % n, fr, fc, mr, mc));
          cells[fr][fc] = 1'b0;
          cells[mr][mc] = 1'b0;
          orow = fr[5:0];
          ocol = fc[5:0];
          cnt  = (n > mfe_pkg::CountSat) ? 15'(mfe_pkg::CountSat) : n[14:0];
        end
      end
    endcase
    expected_results.push_back({2'b00, cnt, ocol, orow, cbit, status});
  endfunction

  function void field_check(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result transfer: compare field by field with the oldest expectation
  function void check_result(logic [31:0] d);
    logic [31:0] e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, d);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    field_check("status", 32'(e[1:0]), 32'(d[1:0]));
    field_check("cell_bit", 32'(e[2]), 32'(d[2]));
    field_check("opened_row", 32'(e[8:3]), 32'(d[8:3]));
    field_check("opened_col", 32'(e[14:9]), 32'(d[14:9]));
    field_check("candidate_count", 32'(e[29:15]), 32'(d[29:15]));
  endfunction
endclass

module tb_maze_frontier_expansion_step;

  localparam int WatchdogLimit = 60000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mfe_pkg::InDataW-1:0]   s_axis_tdata = '0;  // action, cell_row, cell_col, random_value
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mfe_pkg::OutDataW-1:0]  m_axis_tdata;       // status, cell_bit, opened_row,
                                                     // opened_col, candidate_count
  logic                          cfg_we_i = 1'b0;
  logic [mfe_pkg::CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [mfe_pkg::CfgW-1:0]      cfg_wdata_i = '0;

  maze_grid_tracker maze;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  maze_frontier_expansion_step uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) maze.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) maze.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(bit [1:0] act, bit [5:0] row, bit [5:0] col, bit [31:0] rnd);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, rnd, col, row, act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Lower valid, let every result drain and the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (maze.expected_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [6:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    maze.write_reg(idx, val);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    int unsigned roll;
    int unsigned nr, nc;
    nr = maze.used_rows();
    nc = maze.used_cols();
    send_item(mfe_pkg::ActClear, 0, 0, $urandom);
    if (nr > 0 && nc > 0)
      send_item(mfe_pkg::ActOpen, 6'($urandom_range(0, nr - 1)),
                6'($urandom_range(0, nc - 1)), $urandom);
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50 || nr == 0 || nc == 0)
        send_item(mfe_pkg::ActStep, 6'($urandom), 6'($urandom), $urandom);
      else if (roll < 70)
        send_item(mfe_pkg::ActRead, 6'($urandom_range(0, nr - 1)),
                  6'($urandom_range(0, nc - 1)), $urandom);
      else if (roll < 85)
        send_item(mfe_pkg::ActOpen, 6'($urandom_range(0, nr - 1)),
                  6'($urandom_range(0, nc - 1)), $urandom);
      else if (roll < 95)
        send_item(roll[0] ? mfe_pkg::ActOpen : mfe_pkg::ActRead, 6'($urandom),
                  6'($urandom), $urandom);
      else
        send_item(mfe_pkg::ActClear, 6'($urandom), 6'($urandom), $urandom);
    end
  endtask

  initial begin
    maze = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default 16 x 16 grid
    send_item(mfe_pkg::ActRead, 0, 0, 0);
    send_item(mfe_pkg::ActStep, 0, 0, 0);             // no candidate yet
    send_item(mfe_pkg::ActOpen, 1, 1, 0);
    send_item(mfe_pkg::ActRead, 1, 1, 0);
    send_item(mfe_pkg::ActStep, 6'h3F, 6'h3F, 32'h0);
    send_item(mfe_pkg::ActStep, 0, 0, 32'hFFFF_FFFF);
    send_item(mfe_pkg::ActOpen, 6'h3F, 6'h3F, 0);     // out of range
    send_item(mfe_pkg::ActRead, 16, 0, 0);
    send_item(mfe_pkg::ActRead, 0, 16, 0);
    send_item(mfe_pkg::ActClear, 0, 0, 0);
    send_item(mfe_pkg::ActRead, 1, 1, 0);
    drain();

    // Zero-sized grid
    write_reg(mfe_pkg::RegRows, 7'd0);
    write_reg(mfe_pkg::RegCols, 7'd0);
    send_item(mfe_pkg::ActOpen, 0, 0, 0);
    send_item(mfe_pkg::ActRead, 0, 0, 0);
    send_item(mfe_pkg::ActStep, 0, 0, 32'h1234_5678);
    drain();

    // Oversized registers saturate; unused indexes are ignored
    write_reg(mfe_pkg::RegRows, 7'd127);
    write_reg(mfe_pkg::RegCols, 7'd65);
    write_reg(2'd2, 7'd3);
    write_reg(2'd3, 7'd3);
    send_item(mfe_pkg::ActOpen, 63, 63, 0);
    send_item(mfe_pkg::ActRead, 63, 63, 0);
    send_item(mfe_pkg::ActOpen, 0, 0, 0);
    send_item(mfe_pkg::ActStep, 0, 0, 32'hFFFF_FFFF);
    send_item(mfe_pkg::ActStep, 0, 0, 32'h8000_0001);
    send_item(mfe_pkg::ActRead, 62, 63, 0);
    send_item(mfe_pkg::ActClear, 0, 0, 0);
    drain();

    // Single row, full width
    write_reg(mfe_pkg::RegRows, 7'd1);
    write_reg(mfe_pkg::RegCols, 7'd64);
    send_item(mfe_pkg::ActOpen, 0, 5, 0);
    send_item(mfe_pkg::ActStep, 0, 0, 32'd7);
    send_item(mfe_pkg::ActRead, 1, 0, 0);
    drain();

    // Random phases under each idling pattern, small grids of up to 12 x 12
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      write_reg(mfe_pkg::RegRows, 7'($urandom_range(1, 12)));
      write_reg(mfe_pkg::RegCols, 7'($urandom_range(1, 12)));
      random_phase(23);
      drain();
    end

    if (maze.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
